>>> hw/rtl/slst_pkg.sv
`default_nettype none

package slst_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_LISTED    = 3'd4;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_INS_CHK = 10'b0000000010,
        S_INS_CMP = 10'b0000000100,
        S_DEL_RD  = 10'b0000001000,
        S_DEL_CMP = 10'b0000010000,
        S_SHF_CHK = 10'b0000100000,
        S_SHF_WR  = 10'b0001000000,
        S_LST_RD  = 10'b0010000000,
        S_LST_OUT = 10'b0100000000,
        S_RESP    = 10'b1000000000
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/sorted_list_engine_top.sv
`default_nettype none

// channel | beat fields                                  | direction
// s_      | s_tuser: operation, s_tdata: value           | in
// m_      | m_tuser: status, m_tdata: element, m_tlast   | out
//
// one item at a time; s_tready is high only while the sequencer is idle
// insert: larger entries move up one slot from the top down; delete: a scan
// from the bottom, then later entries move down one slot; list: each element
// in turn; all paced by the single registered read port of the entry store
// and the one shared compare unit; reset clears only the count and control
// a stalled m_ side holds the sequencer until the result register frees up

module sorted_list_engine_top (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [slst_pkg::DATA_W-1:0]      s_tdata,   // [31:0] value
    input  wire  [slst_pkg::OP_W-1:0]        s_tuser,   // [1:0] operation
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [slst_pkg::DATA_W-1:0]      m_tdata,   // [31:0] element
    output logic [slst_pkg::STAT_W-1:0]      m_tuser,   // [2:0] status
    output logic                             m_tlast
);

    localparam logic [slst_pkg::CNT_W-1:0] CAP_CNT = slst_pkg::CNT_W'(slst_pkg::CAPACITY);
    localparam logic [slst_pkg::CNT_W-1:0] ONE_CNT = slst_pkg::CNT_W'(1);
    localparam logic [slst_pkg::IDX_W-1:0] ONE_IDX = slst_pkg::IDX_W'(1);

    slst_pkg::state_t                  state_reg, state_next;
    logic [slst_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [slst_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [slst_pkg::DATA_W-1:0]       value_reg, value_next;
    logic [slst_pkg::STAT_W-1:0]       status_reg, status_next;

    logic                              m_tvalid_reg, m_tvalid_next;
    logic [slst_pkg::DATA_W-1:0]       m_tdata_reg, m_tdata_next;
    logic [slst_pkg::STAT_W-1:0]       m_tuser_reg, m_tuser_next;
    logic                              m_tlast_reg, m_tlast_next;

    // entry store: one write port, one registered read port
    logic [slst_pkg::DATA_W-1:0]       mem [slst_pkg::CAPACITY];
    logic [slst_pkg::DATA_W-1:0]       rdata_reg;
    logic                              rd_en;
    logic [slst_pkg::IDX_W-1:0]        rd_addr;
    logic                              mem_we;
    logic [slst_pkg::IDX_W-1:0]        mem_waddr;
    logic [slst_pkg::DATA_W-1:0]       mem_wdata;

    logic                              out_free;
    logic [slst_pkg::CNT_W-1:0]        idx_ext;
    logic [slst_pkg::CNT_W-1:0]        idx_inc;
    logic                              rd_less;
    logic                              rd_equal;

    assign out_free = !m_tvalid_reg || m_tready;
    assign idx_ext  = {{(slst_pkg::CNT_W - slst_pkg::IDX_W){1'b0}}, idx_reg};
    assign idx_inc  = idx_ext + ONE_CNT;
    // shared compare unit
    assign rd_less  = $signed(rdata_reg) < $signed(value_reg);
    assign rd_equal = rdata_reg == value_reg;

    assign s_tready = state_reg == slst_pkg::S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = value_reg;

        unique case (state_reg)
            slst_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    value_next = s_tdata;
                    case (s_tuser)
                        slst_pkg::OP_INSERT: begin
                            if (count_reg == CAP_CNT) begin
                                status_next = slst_pkg::ST_FULL;
                                state_next  = slst_pkg::S_RESP;
                            end else begin
                                idx_next   = count_reg[slst_pkg::IDX_W-1:0];
                                state_next = slst_pkg::S_INS_CHK;
                            end
                        end
                        slst_pkg::OP_DELETE: begin
                            idx_next = '0;
                            if (count_reg == '0) begin
                                status_next = slst_pkg::ST_EMPTY;
                                state_next  = slst_pkg::S_RESP;
                            end else begin
                                state_next = slst_pkg::S_DEL_RD;
                            end
                        end
                        slst_pkg::OP_LIST: begin
                            idx_next = '0;
                            if (count_reg == '0) begin
                                status_next = slst_pkg::ST_EMPTY;
                                state_next  = slst_pkg::S_RESP;
                            end else begin
                                state_next = slst_pkg::S_LST_RD;
                            end
                        end
                        default: state_next = slst_pkg::S_IDLE;
                    endcase
                end
            end
            // walk down from the top, moving larger entries up one slot
            slst_pkg::S_INS_CHK: begin
                if (idx_reg == '0) begin
                    mem_we      = 1'b1;
                    count_next  = count_reg + ONE_CNT;
                    status_next = slst_pkg::ST_DONE;
                    state_next  = slst_pkg::S_RESP;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg - ONE_IDX;
                    state_next = slst_pkg::S_INS_CMP;
                end
            end
            slst_pkg::S_INS_CMP: begin
                mem_we = 1'b1;
                if (rd_less) begin
                    count_next  = count_reg + ONE_CNT;
                    status_next = slst_pkg::ST_DONE;
                    state_next  = slst_pkg::S_RESP;
                end else begin
                    mem_wdata  = rdata_reg;
                    idx_next   = idx_reg - ONE_IDX;
                    state_next = slst_pkg::S_INS_CHK;
                end
            end
            slst_pkg::S_DEL_RD: begin
                rd_en      = 1'b1;
                state_next = slst_pkg::S_DEL_CMP;
            end
            slst_pkg::S_DEL_CMP: begin
                if (rd_equal) begin
                    state_next = slst_pkg::S_SHF_CHK;
                end else if (idx_inc == count_reg) begin
                    status_next = slst_pkg::ST_NOT_FOUND;
                    state_next  = slst_pkg::S_RESP;
                end else begin
                    idx_next   = idx_reg + ONE_IDX;
                    state_next = slst_pkg::S_DEL_RD;
                end
            end
            // close the gap by moving later entries down one slot
            slst_pkg::S_SHF_CHK: begin
                if (idx_inc == count_reg) begin
                    count_next  = count_reg - ONE_CNT;
                    status_next = slst_pkg::ST_DONE;
                    state_next  = slst_pkg::S_RESP;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg + ONE_IDX;
                    state_next = slst_pkg::S_SHF_WR;
                end
            end
            slst_pkg::S_SHF_WR: begin
                mem_we     = 1'b1;
                mem_wdata  = rdata_reg;
                idx_next   = idx_reg + ONE_IDX;
                state_next = slst_pkg::S_SHF_CHK;
            end
            slst_pkg::S_LST_RD: begin
                rd_en      = 1'b1;
                state_next = slst_pkg::S_LST_OUT;
            end
            slst_pkg::S_LST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rdata_reg;
                    m_tuser_next  = slst_pkg::ST_LISTED;
                    m_tlast_next  = idx_inc == count_reg;
                    if (idx_inc == count_reg) begin
                        state_next = slst_pkg::S_IDLE;
                    end else begin
                        idx_next   = idx_reg + ONE_IDX;
                        state_next = slst_pkg::S_LST_RD;
                    end
                end
            end
            slst_pkg::S_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tuser_next  = status_reg;
                    m_tlast_next  = 1'b1;
                    state_next    = slst_pkg::S_IDLE;
                end
            end
            default: state_next = slst_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= slst_pkg::S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

`default_nettype wire
